// ----- sv/esc_dfr_pkg.sv -----
package esc_dfr_pkg;

  typedef enum logic [1:0] {
    MODE_HUNT  = 2'd0,
    MODE_FRAME = 2'd1,
    MODE_ESC   = 2'd2,
    MODE_DROP  = 2'd3
  } mode_e;

  typedef enum logic [2:0] {
    ST_CONSUMED = 3'd0,
    ST_DATA     = 3'd1,
    ST_END      = 3'd2,
    ST_NOISE    = 3'd3,
    ST_BADESC   = 3'd4,
    ST_RESTART  = 3'd5,
    ST_OVERSIZE = 3'd6
  } status_e;

  typedef enum logic [2:0] {
    REG_START_CODE   = 3'd0,
    REG_END_CODE     = 3'd1,
    REG_ESCAPE_CODE  = 3'd2,
    REG_ESC_START    = 3'd3,
    REG_ESC_END      = 3'd4,
    REG_ESC_ESCAPE   = 3'd5,
    REG_MAX_LENGTH   = 3'd6
  } reg_idx_e;

  localparam int unsigned CfgIdxW  = 3;
  localparam int unsigned CfgDataW = 16;

  typedef struct packed {
    logic [7:0]  start_code;
    logic [7:0]  end_code;
    logic [7:0]  escape_code;
    logic [7:0]  escaped_start_code;
    logic [7:0]  escaped_end_code;
    logic [7:0]  escaped_escape_code;
    logic [15:0] max_length;
  } cfg_t;

  localparam cfg_t CfgReset = '{
    start_code:          8'd2,
    end_code:            8'd3,
    escape_code:         8'd16,
    escaped_start_code:  8'd130,
    escaped_end_code:    8'd131,
    escaped_escape_code: 8'd144,
    max_length:          16'hFFFF
  };

  typedef struct packed {
    status_e     status;
    logic [7:0]  data_byte;
    logic [15:0] frame_length;
  } result_t;

endpackage

// ----- sv/esc_dfr_decode.sv -----
module esc_dfr_decode (
  input  esc_dfr_pkg::cfg_t    cfg_i,
  input  esc_dfr_pkg::mode_e   mode_i,
  input  logic [15:0]          count_i,
  input  logic [7:0]           rx_byte_i,
  output esc_dfr_pkg::mode_e   mode_o,
  output logic [15:0]          count_o,
  output esc_dfr_pkg::result_t result_o
);

  logic       take_payload;
  logic [7:0] pay_byte;

  always_comb begin
    mode_o       = mode_i;
    count_o      = count_i;
    result_o     = '{status: esc_dfr_pkg::ST_CONSUMED, data_byte: 8'd0, frame_length: 16'd0};
    take_payload = 1'b0;
    pay_byte     = rx_byte_i;

    unique case (mode_i)
      esc_dfr_pkg::MODE_HUNT: begin
        if (rx_byte_i == cfg_i.start_code) begin
          mode_o  = esc_dfr_pkg::MODE_FRAME;
          count_o = 16'd0;
        end else begin
          result_o.status = esc_dfr_pkg::ST_NOISE;
        end
      end
      esc_dfr_pkg::MODE_FRAME: begin
        if (rx_byte_i == cfg_i.end_code) begin
          result_o.status       = esc_dfr_pkg::ST_END;
          result_o.frame_length = count_i;
          mode_o                = esc_dfr_pkg::MODE_HUNT;
          count_o               = 16'd0;
        end else if (rx_byte_i == cfg_i.start_code) begin
          result_o.status = esc_dfr_pkg::ST_RESTART;
          count_o         = 16'd0;
        end else if (rx_byte_i == cfg_i.escape_code) begin
          mode_o = esc_dfr_pkg::MODE_ESC;
        end else begin
          take_payload = 1'b1;
        end
      end
      esc_dfr_pkg::MODE_ESC: begin
        if (rx_byte_i == cfg_i.escaped_start_code) begin
          take_payload = 1'b1;
          pay_byte     = cfg_i.start_code;
        end else if (rx_byte_i == cfg_i.escaped_end_code) begin
          take_payload = 1'b1;
          pay_byte     = cfg_i.end_code;
        end else if (rx_byte_i == cfg_i.escaped_escape_code) begin
          take_payload = 1'b1;
          pay_byte     = cfg_i.escape_code;
        end else begin
          result_o.status = esc_dfr_pkg::ST_BADESC;
          mode_o          = esc_dfr_pkg::MODE_HUNT;
          count_o         = 16'd0;
        end
      end
      default: begin
        // Dropping the rest of an oversized frame; end code wins over start code.
        if (rx_byte_i == cfg_i.end_code) begin
          mode_o  = esc_dfr_pkg::MODE_HUNT;
          count_o = 16'd0;
        end else if (rx_byte_i == cfg_i.start_code) begin
          mode_o  = esc_dfr_pkg::MODE_FRAME;
          count_o = 16'd0;
        end
      end
    endcase

    if (take_payload) begin
      if (count_i >= cfg_i.max_length) begin
        mode_o          = esc_dfr_pkg::MODE_DROP;
        result_o.status = esc_dfr_pkg::ST_OVERSIZE;
      end else begin
        mode_o             = esc_dfr_pkg::MODE_FRAME;
        count_o            = count_i + 16'd1;
        result_o.status    = esc_dfr_pkg::ST_DATA;
        result_o.data_byte = pay_byte;
      end
    end
  end

endmodule

// ----- sv/escaped_frame_deframer.sv -----
// Byte-stuffed frame decoder for a serial link.
// Raw line bytes arrive on the s_axis channel, one per transaction, and for
// each byte exactly one status transaction leaves on m_axis: tuser carries the
// status code, tdata carries the decoded payload byte and, at frame end, the
// frame length. Start, end and escape codes, the three escape followers and
// the length limit sit in registers written through the cfg channel, which
// is always ready and should only be used while no bytes are in flight.
// A byte goes into an input register, then through the decoder into the
// result register, from which its status is offered on m_axis. One byte per
// cycle is sustained while m_axis_tready stays high; the mode and byte-count
// registers are updated in the same cycle as the decode, so consecutive
// bytes never wait.
// When the receiver stalls, the result register holds and the input register
// still takes one more byte; the input side stalls only when both are full.
// Reset returns the codes and limit to their defaults, empties both
// registers and puts the decoder in hunting mode with a zero byte count.
module escaped_frame_deframer (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  input  logic                                 s_axis_tvalid,
  output logic                                 s_axis_tready,
  input  logic [7:0]                           s_axis_tdata,   // [7:0] rx_byte
  output logic                                 m_axis_tvalid,
  input  logic                                 m_axis_tready,
  output logic [23:0]                          m_axis_tdata,   // [7:0] data_byte,
                                                               // [23:8] frame_length
  output logic [2:0]                           m_axis_tuser,   // [2:0] status
  input  logic                                 cfg_valid_i,
  output logic                                 cfg_ready_o,
  input  logic [esc_dfr_pkg::CfgIdxW-1:0]      cfg_index_i,
  input  logic [esc_dfr_pkg::CfgDataW-1:0]     cfg_data_i
);

  esc_dfr_pkg::cfg_t    cfg_q, cfg_d;
  esc_dfr_pkg::mode_e   mode_q, mode_d;
  logic [15:0]          count_q, count_d;
  logic                 in_valid_q;
  logic [7:0]           in_byte_q;
  logic                 out_valid_q;
  esc_dfr_pkg::result_t out_q, result_d;
  logic                 out_free;
  logic                 advance;

  assign cfg_ready_o = 1'b1;

  always_comb begin
    cfg_d = cfg_q;
    if (cfg_valid_i) begin
      unique case (cfg_index_i)
        esc_dfr_pkg::REG_START_CODE:  cfg_d.start_code          = cfg_data_i[7:0];
        esc_dfr_pkg::REG_END_CODE:    cfg_d.end_code            = cfg_data_i[7:0];
        esc_dfr_pkg::REG_ESCAPE_CODE: cfg_d.escape_code         = cfg_data_i[7:0];
        esc_dfr_pkg::REG_ESC_START:   cfg_d.escaped_start_code  = cfg_data_i[7:0];
        esc_dfr_pkg::REG_ESC_END:     cfg_d.escaped_end_code    = cfg_data_i[7:0];
        esc_dfr_pkg::REG_ESC_ESCAPE:  cfg_d.escaped_escape_code = cfg_data_i[7:0];
        esc_dfr_pkg::REG_MAX_LENGTH:  cfg_d.max_length          = cfg_data_i;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q <= esc_dfr_pkg::CfgReset;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  assign out_free      = !out_valid_q || m_axis_tready;
  assign advance       = in_valid_q && out_free;
  assign s_axis_tready = !in_valid_q || out_free;

  esc_dfr_decode u_decode (
    .cfg_i     (cfg_q),
    .mode_i    (mode_q),
    .count_i   (count_q),
    .rx_byte_i (in_byte_q),
    .mode_o    (mode_d),
    .count_o   (count_d),
    .result_o  (result_d)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
      mode_q      <= esc_dfr_pkg::MODE_HUNT;
      count_q     <= 16'd0;
    end else begin
      if (s_axis_tready) begin
        in_valid_q <= s_axis_tvalid;
      end
      if (out_free) begin
        out_valid_q <= in_valid_q;
      end
      if (advance) begin
        mode_q  <= mode_d;
        count_q <= count_d;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (s_axis_tready && s_axis_tvalid) begin
      in_byte_q <= s_axis_tdata;
    end
    if (advance) begin
      out_q <= result_d;
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = {out_q.frame_length, out_q.data_byte};
  assign m_axis_tuser  = out_q.status;

`ifndef ASSERT_OFF
  a_end_returns_to_hunt: assert property (@(posedge clk_i) disable iff (!rst_ni)
    advance && (result_d.status == esc_dfr_pkg::ST_END) |=> mode_q == esc_dfr_pkg::MODE_HUNT)
    else $error("frame end did not return the decoder to hunting");

  a_length_only_at_end: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && (out_q.status != esc_dfr_pkg::ST_END) |-> out_q.frame_length == 16'd0)
    else $error("frame length nonzero outside frame end");

  a_data_only_when_data: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && (out_q.status != esc_dfr_pkg::ST_DATA) |-> out_q.data_byte == 8'd0)
    else $error("data byte nonzero outside a data result");

  a_advance_fills_output: assert property (@(posedge clk_i) disable iff (!rst_ni)
    advance |=> out_valid_q)
    else $error("decoded byte lost between input and result registers");

  a_stall_means_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !s_axis_tready |-> in_valid_q && out_valid_q)
    else $error("input stalled while a register was free");
`endif

endmodule

// ----- verif/esc_dfr_checker.sv -----
`timescale 1ns / 1ps

module esc_dfr_checker
  import esc_dfr_pkg::*;
(
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                s_axis_tvalid,
  input  logic                s_axis_tready,
  input  logic [7:0]          s_axis_tdata,   // [7:0] rx_byte
  input  logic                m_axis_tvalid,
  input  logic                m_axis_tready,
  input  logic [23:0]         m_axis_tdata,   // [7:0] data_byte, [23:8] frame_length
  input  logic [2:0]          m_axis_tuser,   // [2:0] status
  input  logic                cfg_valid_i,
  input  logic                cfg_ready_i,
  input  logic [CfgIdxW-1:0]  cfg_index_i,
  input  logic [CfgDataW-1:0] cfg_data_i,
  output int unsigned         mismatches_o,
  output int unsigned         outstanding_o
);

  cfg_t        codes_q;
  mode_e       mode_q;
  logic [15:0] payload_cnt_q;
  result_t     expected_q[$];
  int unsigned mismatches = 0;
  int unsigned outstanding = 0;

  assign mismatches_o  = mismatches;
  assign outstanding_o = outstanding;

  // Counts one decoded payload byte against the length limit.
  task automatic take_payload(input logic [7:0] b, output result_t r);
    r.frame_length = 16'd0;
    if (payload_cnt_q >= codes_q.max_length) begin
      mode_q      = MODE_DROP;
      r.status    = ST_OVERSIZE;
      r.data_byte = 8'd0;
    end else begin
      payload_cnt_q = payload_cnt_q + 16'd1;
      mode_q        = MODE_FRAME;
      r.status      = ST_DATA;
      r.data_byte   = b;
    end
  endtask

  task automatic decode_byte(input logic [7:0] b, output result_t r);
    r.status       = ST_CONSUMED;
    r.data_byte    = 8'd0;
    r.frame_length = 16'd0;
    case (mode_q)
      MODE_HUNT: begin
        if (b == codes_q.start_code) begin
          mode_q        = MODE_FRAME;
          payload_cnt_q = 16'd0;
        end else begin
          r.status = ST_NOISE;
        end
      end
      MODE_FRAME: begin
        // End code wins over start code, which wins over escape code.
        if (b == codes_q.end_code) begin
          r.status       = ST_END;
          r.frame_length = payload_cnt_q;
          mode_q         = MODE_HUNT;
          payload_cnt_q  = 16'd0;
        end else if (b == codes_q.start_code) begin
          payload_cnt_q = 16'd0;
          r.status      = ST_RESTART;
        end else if (b == codes_q.escape_code) begin
          mode_q = MODE_ESC;
        end else begin
          take_payload(b, r);
        end
      end
      MODE_ESC: begin
        if (b == codes_q.escaped_start_code) begin
          take_payload(codes_q.start_code, r);
        end else if (b == codes_q.escaped_end_code) begin
          take_payload(codes_q.end_code, r);
        end else if (b == codes_q.escaped_escape_code) begin
          take_payload(codes_q.escape_code, r);
        end else begin
          mode_q        = MODE_HUNT;
          payload_cnt_q = 16'd0;
          r.status      = ST_BADESC;
        end
      end
      default: begin
        if (b == codes_q.end_code) begin
          mode_q        = MODE_HUNT;
          payload_cnt_q = 16'd0;
        end else if (b == codes_q.start_code) begin
          mode_q        = MODE_FRAME;
          payload_cnt_q = 16'd0;
        end
      end
    endcase
  endtask

  always @(posedge clk_i or negedge rst_ni) begin : monitor
    result_t want;
    result_t got;
    if (!rst_ni) begin
      codes_q       = CfgReset;
      mode_q        = MODE_HUNT;
      payload_cnt_q = 16'd0;
      expected_q.delete();
    end else begin
      if (cfg_valid_i && cfg_ready_i) begin
        case (cfg_index_i)
          REG_START_CODE:  codes_q.start_code          = cfg_data_i[7:0];
          REG_END_CODE:    codes_q.end_code            = cfg_data_i[7:0];
          REG_ESCAPE_CODE: codes_q.escape_code         = cfg_data_i[7:0];
          REG_ESC_START:   codes_q.escaped_start_code  = cfg_data_i[7:0];
          REG_ESC_END:     codes_q.escaped_end_code    = cfg_data_i[7:0];
          REG_ESC_ESCAPE:  codes_q.escaped_escape_code = cfg_data_i[7:0];
          REG_MAX_LENGTH:  codes_q.max_length          = cfg_data_i;
          default: ;
        endcase
      end
      if (m_axis_tvalid && m_axis_tready) begin
        got.status       = status_e'(m_axis_tuser);
        got.data_byte    = m_axis_tdata[7:0];
        got.frame_length = m_axis_tdata[23:8];
        if (expected_q.size() == 0) begin
          mismatches++;
          if (mismatches <= 10)
            $display("%0t: unexpected status transaction: status %0d data_byte %02h %s %0d",
                     $realtime, m_axis_tuser, got.data_byte, "frame_length",
                     got.frame_length);
        end else begin
          want = expected_q.pop_front();
          if (got.status !== want.status || got.data_byte !== want.data_byte ||
              got.frame_length !== want.frame_length) begin
            mismatches++;
            if (mismatches <= 10)
              $display("%0t: mismatch: status exp %0d got %0d, data_byte exp %02h %s %02h, %s %0d got %0d",
                       $realtime, want.status, m_axis_tuser, want.data_byte, "got",
                       got.data_byte, "frame_length exp", want.frame_length,
                       got.frame_length);
          end
        end
      end
      if (s_axis_tvalid && s_axis_tready) begin
        decode_byte(s_axis_tdata, want);
        expected_q.push_back(want);
      end
    end
    outstanding = expected_q.size();
  end

endmodule

// ----- verif/tb_top.sv -----
`timescale 1ns / 1ps

module tb_top;
  import esc_dfr_pkg::*;

  localparam int unsigned PhaseCount  = 10;
  localparam int unsigned PhaseItems  = 130;
  localparam int unsigned QuietLimit  = 4000;
  localparam int unsigned DrainCycles = 6;
  localparam logic [CfgIdxW-1:0] RegIdxSpare = 3'd7;

  logic                clk_i         = 1'b0;
  logic                rst_ni        = 1'b0;
  logic                s_axis_tvalid = 1'b0;
  logic                s_axis_tready;
  logic [7:0]          s_axis_tdata  = 8'd0;
  logic                m_axis_tvalid;
  logic                m_axis_tready = 1'b0;
  logic [23:0]         m_axis_tdata;
  logic [2:0]          m_axis_tuser;
  logic                cfg_valid_i   = 1'b0;
  logic                cfg_ready_o;
  logic [CfgIdxW-1:0]  cfg_index_i   = '0;
  logic [CfgDataW-1:0] cfg_data_i    = '0;

  int unsigned mismatches;
  int unsigned outstanding;
  int unsigned quiet_cycles = 0;
  int unsigned items_sent   = 0;
  int unsigned burst_left   = 0;
  bit          no_gaps      = 1'b0;
  logic [9:0]  stall_phase  = '0;
  cfg_t        cur          = CfgReset;

  escaped_frame_deframer dut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata (s_axis_tdata),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata),
    .m_axis_tuser (m_axis_tuser),
    .cfg_valid_i  (cfg_valid_i),
    .cfg_ready_o  (cfg_ready_o),
    .cfg_index_i  (cfg_index_i),
    .cfg_data_i   (cfg_data_i)
  );

  esc_dfr_checker u_checker (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata (s_axis_tdata),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata),
    .m_axis_tuser (m_axis_tuser),
    .cfg_valid_i  (cfg_valid_i),
    .cfg_ready_i  (cfg_ready_o),
    .cfg_index_i  (cfg_index_i),
    .cfg_data_i   (cfg_data_i),
    .mismatches_o (mismatches),
    .outstanding_o(outstanding)
  );

  initial begin
    forever #5 clk_i = ~clk_i;
  end

  // The receiver cycles through always ready, coin flips, heavy stalls and a fixed duty pattern.
  always @(posedge clk_i) begin
    stall_phase <= stall_phase + 10'd1;
    case (stall_phase[9:8])
      2'd0:    m_axis_tready <= 1'b1;
      2'd1:    m_axis_tready <= 1'($urandom_range(0, 1));
      2'd2:    m_axis_tready <= ($urandom_range(0, 4) == 0);
      default: m_axis_tready <= (stall_phase[2:0] < 3'd5);
    endcase
  end

  always @(posedge clk_i) begin
    if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) ||
        (cfg_valid_i && cfg_ready_o))
      quiet_cycles <= 0;
    else
      quiet_cycles <= quiet_cycles + 1;
  end

  initial begin : watchdog
    wait (quiet_cycles >= QuietLimit);
    $display("CHECKS FAILED");
    $finish;
  end

  // Leaves tvalid high on return so back-to-back bytes need no extra assignment.
  task automatic push_byte(input logic [7:0] b);
    int unsigned gap;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 24);
      gap = (no_gaps || $urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
      if (gap != 0) begin
        s_axis_tvalid <= 1'b0;
        repeat (gap) @(posedge clk_i);
      end
    end
    burst_left--;
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= b;
    do @(posedge clk_i); while (!s_axis_tready);
    items_sent++;
  endtask

  task automatic settle();
    s_axis_tvalid <= 1'b0;
    burst_left = 0;
    do @(posedge clk_i); while (outstanding != 0);
    repeat (DrainCycles) @(posedge clk_i);
  endtask

  task automatic write_reg(input logic [CfgIdxW-1:0] idx, input logic [CfgDataW-1:0] val);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= val;
    do @(posedge clk_i); while (!cfg_ready_o);
  endtask

  // Upper bits of the byte-wide registers carry junk that must be ignored.
  task automatic load_codes(input cfg_t c, input bit with_spare);
    write_reg(REG_START_CODE,  {8'($urandom), c.start_code});
    write_reg(REG_END_CODE,    {8'($urandom), c.end_code});
    write_reg(REG_ESCAPE_CODE, {8'($urandom), c.escape_code});
    write_reg(REG_ESC_START,   {8'($urandom), c.escaped_start_code});
    write_reg(REG_ESC_END,     {8'($urandom), c.escaped_end_code});
    write_reg(REG_ESC_ESCAPE,  {8'($urandom), c.escaped_escape_code});
    write_reg(REG_MAX_LENGTH,  c.max_length);
    if (with_spare)
      write_reg(RegIdxSpare, 16'($urandom));
    cfg_valid_i <= 1'b0;
    cur = c;
  endtask

  // Stuffs one payload byte the way a well-behaved framer would.
  task automatic send_payload(input logic [7:0] pb);
    if (pb == cur.end_code) begin
      push_byte(cur.escape_code);
      push_byte(cur.escaped_end_code);
    end else if (pb == cur.start_code) begin
      push_byte(cur.escape_code);
      push_byte(cur.escaped_start_code);
    end else if (pb == cur.escape_code) begin
      push_byte(cur.escape_code);
      push_byte(cur.escaped_escape_code);
    end else begin
      push_byte(pb);
    end
  endtask

  function automatic logic [7:0] payload_pick();
    case ($urandom_range(0, 7))
      0:       return cur.start_code;
      1:       return cur.end_code;
      2:       return cur.escape_code;
      3:       return cur.escaped_end_code;
      default: return 8'($urandom);
    endcase
  endfunction

  task automatic send_frame();
    int unsigned len;
    len = (cur.max_length <= 16) ? $urandom_range(0, cur.max_length + 3) : $urandom_range(0, 24);
    push_byte(cur.start_code);
    repeat (len) send_payload(payload_pick());
    push_byte(cur.end_code);
  endtask

  initial begin : stimulus
    cfg_t        next_cfg;
    int unsigned kind;
    int unsigned phase_base;

    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Reset codes: noise, every escape, a restart, a frame end and a bad escape.
    push_byte(8'h00);
    push_byte(8'hFF);
    push_byte(cur.end_code);
    push_byte(cur.start_code);
    push_byte(8'h00);
    push_byte(8'hFF);
    push_byte(cur.escape_code);
    push_byte(cur.escaped_start_code);
    push_byte(cur.escape_code);
    push_byte(cur.escaped_end_code);
    push_byte(cur.escape_code);
    push_byte(cur.escaped_escape_code);
    push_byte(cur.start_code);
    push_byte(8'h41);
    push_byte(cur.end_code);
    push_byte(cur.start_code);
    push_byte(cur.escape_code);
    push_byte(cur.start_code);
    settle();

    // Zero length limit: the first payload byte overflows, then dropping until start or end.
    next_cfg = CfgReset;
    next_cfg.max_length = 16'd0;
    load_codes(next_cfg, 1'b1);
    push_byte(cur.start_code);
    push_byte(8'h5A);
    push_byte(cur.escape_code);
    push_byte(cur.start_code);
    push_byte(cur.escape_code);
    push_byte(cur.escaped_start_code);
    push_byte(cur.end_code);

    for (int unsigned p = 0; p < PhaseCount; p++) begin
      settle();
      kind = (p < 4) ? p : $urandom_range(0, 3);
      case (kind)
        0: next_cfg = '{start_code: 8'h00, end_code: 8'hFF, escape_code: 8'h80,
                        escaped_start_code: 8'hFF, escaped_end_code: 8'h00,
                        escaped_escape_code: 8'h7F, max_length: 16'hFFFF};
        1: begin
          // Codes drawn from a tiny pool so that they often coincide.
          next_cfg.start_code          = 8'($urandom_range(0, 3));
          next_cfg.end_code            = 8'($urandom_range(0, 3));
          next_cfg.escape_code         = 8'($urandom_range(0, 3));
          next_cfg.escaped_start_code  = 8'($urandom_range(0, 3));
          next_cfg.escaped_end_code    = 8'($urandom_range(0, 3));
          next_cfg.escaped_escape_code = 8'($urandom_range(0, 3));
          next_cfg.max_length          = 16'($urandom_range(1, 8));
        end
        2: next_cfg = '{start_code: 8'hFF, end_code: 8'h00, escape_code: 8'h7F,
                        escaped_start_code: 8'h00, escaped_end_code: 8'hFF,
                        escaped_escape_code: 8'h80, max_length: 16'h0000};
        default: begin
          next_cfg.start_code          = 8'($urandom);
          next_cfg.end_code            = 8'($urandom);
          next_cfg.escape_code         = 8'($urandom);
          next_cfg.escaped_start_code  = 8'($urandom);
          next_cfg.escaped_end_code    = 8'($urandom);
          next_cfg.escaped_escape_code = 8'($urandom);
          next_cfg.max_length = ($urandom_range(0, 2) != 0) ? 16'($urandom_range(0, 12))
                                                            : 16'($urandom);
        end
      endcase
      load_codes(next_cfg, 1'b0);
      no_gaps    = ($urandom_range(0, 3) == 0);
      phase_base = items_sent;
      while (items_sent - phase_base < PhaseItems) begin
        case ($urandom_range(0, 9))
          0: repeat ($urandom_range(1, 5)) push_byte(8'($urandom));
          1: begin
            // A frame cut short by an escape with an arbitrary follower.
            push_byte(cur.start_code);
            repeat ($urandom_range(0, 3)) send_payload(payload_pick());
            push_byte(cur.escape_code);
            push_byte(8'($urandom));
          end
          2: begin
            // Left open, so the next start code can land as a restart.
            push_byte(cur.start_code);
            repeat ($urandom_range(0, 4)) send_payload(payload_pick());
          end
          default: send_frame();
        endcase
      end
    end
    settle();

    if (mismatches == 0 && outstanding == 0)
      $display("ALL CHECKS PASSED");
    else
      $display("CHECKS FAILED");
    $finish;
  end

endmodule
